FILE: sv/dtt_pkg.sv
// ----------------------------------------------------------------------------
// Directive text tokenizer package
// Shared types, character codes, token kinds and helper functions.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int POSITION_BITS = 16;
  localparam int ACC_BITS      = 32;
  localparam int VALUE_BITS    = 37;
  localparam int TAG_BITS      = 4;
  localparam logic [7:0] VARIABLE_TAG  = 8'd1;
  localparam logic [7:0] PARAMETER_TAG = 8'd2;
  localparam logic [7:0] TAG_MASK      = 8'((1 << TAG_BITS) - 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POSITION_BITS-1:0] INCLUDE_LENGTH = POSITION_BITS'(8);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_C  = 8'h43;
  localparam logic [7:0] CHAR_UP_P  = 8'h50;
  localparam logic [7:0] CHAR_UP_V  = 8'h56;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_KEYWORD,
    MODE_STRING,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_STRAY
  } mode_t;

  typedef enum logic [2:0] {
    KIND_INCLUDE,
    KIND_STRING,
    KIND_NUMBER,
    KIND_IDENT,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_COMMA,
    KIND_COMMENT
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS-1:0] length;
    logic [VALUE_BITS-1:0]    value;
    logic                     last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_ident_char(input logic [7:0] c);
    return (c == CHAR_UNDER) || (c >= CHAR_LO_A && c <= CHAR_LO_Z) ||
           (c >= CHAR_UP_A && c <= CHAR_UP_Z);
  endfunction

  function automatic logic is_digit_char(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // "#include", one character per matched count
  function automatic logic [7:0] keyword_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CHAR_HASH;
      3'd1:    ch = 8'h69;
      3'd2:    ch = 8'h6E;
      3'd3:    ch = 8'h63;
      3'd4:    ch = 8'h6C;
      3'd5:    ch = 8'h75;
      3'd6:    ch = 8'h64;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  function automatic logic [VALUE_BITS-1:0] number_value_f(input logic [ACC_BITS-1:0] acc,
                                                          input logic tagged_num,
                                                          input logic [7:0] tag);
    logic [VALUE_BITS-1:0] packed_val;
    packed_val = VALUE_BITS'(acc);
    if (tagged_num) begin
      packed_val = (packed_val << TAG_BITS) | VALUE_BITS'(tag & TAG_MASK);
    end
    return VALUE_BITS'(0) - packed_val;
  endfunction

  function automatic token_t make_token(input kind_t kind,
                                        input logic [POSITION_BITS-1:0] start,
                                        input logic [POSITION_BITS-1:0] length,
                                        input logic [VALUE_BITS-1:0] value);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.value  = value;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

FILE: sv/dtt_lexer.sv
// ----------------------------------------------------------------------------
// Directive text tokenizer lexer
// Input byte register, lexer state and the per-byte step that yields up to
// two tokens and the next state.
// ----------------------------------------------------------------------------
module dtt_lexer (
  input  logic           clk,
  input  logic           rst,
  input  logic           text_valid,
  output logic           text_stall,
  input  logic [7:0]     text_byte,
  input  logic           room,
  output dtt_pkg::push_t push
);
  import dtt_pkg::*;

  logic                     in_full;
  logic [7:0]               byte_r;
  logic                     step;

  mode_t                    mode;
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] token_begin;
  logic [2:0]               keyword_matched;
  logic [ACC_BITS-1:0]      digit_accumulator;
  logic                     star_seen;

  mode_t                    mode_next;
  logic [POSITION_BITS-1:0] position_next;
  logic [POSITION_BITS-1:0] begin_next;
  logic [2:0]               matched_next;
  logic [ACC_BITS-1:0]      acc_next;
  logic                     star_next;

  logic                     em_a, em_b, em_c;
  token_t                   tok_a, tok_b, tok_c;
  logic                     ident_chk, disp;
  logic [POSITION_BITS-1:0] len;
  logic [ACC_BITS+3:0]      acc_mul;
  logic [1:0]               n;
  token_t                   tok0, tok1;

  assign step       = in_full && room;
  assign text_stall = in_full && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      byte_r <= text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      byte_position     <= '0;
      token_begin       <= '0;
      keyword_matched   <= '0;
      digit_accumulator <= '0;
      star_seen         <= 1'b0;
    end else if (step) begin
      mode              <= mode_next;
      byte_position     <= position_next;
      token_begin       <= begin_next;
      keyword_matched   <= matched_next;
      digit_accumulator <= acc_next;
      star_seen         <= star_next;
    end
  end

  always_comb begin
    mode_next     = mode;
    begin_next    = token_begin;
    matched_next  = keyword_matched;
    acc_next      = digit_accumulator;
    star_next     = star_seen;
    position_next = byte_position + POSITION_BITS'(1);
    em_a = 1'b0; em_b = 1'b0; em_c = 1'b0;
    tok_a = '0;  tok_b = '0;  tok_c = '0;
    ident_chk = 1'b0;
    disp      = 1'b0;
    len       = byte_position - token_begin;
    acc_mul   = (ACC_BITS+4)'({digit_accumulator, 3'b000}) +
                (ACC_BITS+4)'({digit_accumulator, 1'b0}) +
                (ACC_BITS+4)'(byte_r[3:0]);

    if (byte_r == CHAR_NUL) begin
      // end of text: flush pending token, restart at offset zero
      unique case (mode)
        MODE_KEYWORD: begin
          if (keyword_matched >= 3'd2) begin
            em_a  = 1'b1;
            tok_a = make_token(KIND_IDENT, token_begin + POSITION_BITS'(1),
                               POSITION_BITS'(keyword_matched - 3'd1), '0);
          end
        end
        MODE_NUMBER: begin
          em_a  = 1'b1;
          tok_a = make_token(KIND_NUMBER, token_begin, len,
                             number_value_f(digit_accumulator, 1'b0, '0));
        end
        MODE_IDENT: begin
          em_a  = 1'b1;
          tok_a = make_token(KIND_IDENT, token_begin, len, '0);
        end
        MODE_LINE, MODE_BLOCK: begin
          em_a  = 1'b1;
          tok_a = make_token(KIND_COMMENT, token_begin, len, '0);
        end
        default: ;
      endcase
      mode_next     = MODE_IDLE;
      begin_next    = '0;
      matched_next  = '0;
      acc_next      = '0;
      star_next     = 1'b0;
      position_next = '0;
    end else begin
      unique case (mode)
        MODE_KEYWORD: begin
          if (byte_r == keyword_char(keyword_matched)) begin
            if (keyword_matched == 3'd7) begin
              em_a         = 1'b1;
              tok_a        = make_token(KIND_INCLUDE, token_begin, INCLUDE_LENGTH, '0);
              mode_next    = MODE_IDLE;
              matched_next = '0;
            end else begin
              matched_next = keyword_matched + 3'd1;
            end
          end else if (keyword_matched >= 3'd2) begin
            // drop the '#', keep the matched letters as an identifier
            mode_next    = MODE_IDENT;
            begin_next   = token_begin + POSITION_BITS'(1);
            matched_next = '0;
            ident_chk    = 1'b1;
          end else begin
            mode_next    = MODE_IDLE;
            matched_next = '0;
            disp         = 1'b1;
          end
        end
        MODE_STRING: begin
          if (byte_r == CHAR_QUOTE) begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_STRING, token_begin, len, '0);
            mode_next = MODE_IDLE;
          end else if (byte_r == CHAR_LF) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (is_digit_char(byte_r)) begin
            acc_next = (acc_mul[ACC_BITS+3:ACC_BITS] != '0) ? '1 : acc_mul[ACC_BITS-1:0];
          end else if (byte_r == CHAR_UP_V) begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_NUMBER, token_begin, len + POSITION_BITS'(1),
                                   number_value_f(digit_accumulator, 1'b1, VARIABLE_TAG));
            mode_next = MODE_IDLE;
            acc_next  = '0;
          end else if (byte_r == CHAR_UP_P || byte_r == CHAR_UP_C) begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_NUMBER, token_begin, len + POSITION_BITS'(1),
                                   number_value_f(digit_accumulator, 1'b1, PARAMETER_TAG));
            mode_next = MODE_IDLE;
            acc_next  = '0;
          end else begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_NUMBER, token_begin, len,
                                   number_value_f(digit_accumulator, 1'b0, '0));
            mode_next = MODE_IDLE;
            acc_next  = '0;
            disp      = 1'b1;
          end
        end
        MODE_IDENT: begin
          ident_chk = 1'b1;
        end
        MODE_SLASH: begin
          if (byte_r == CHAR_SLASH) begin
            mode_next = MODE_LINE;
          end else if (byte_r == CHAR_STAR) begin
            mode_next = MODE_BLOCK;
            star_next = 1'b0;
          end else if (byte_r == CHAR_LF) begin
            mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_STRAY;
          end
        end
        MODE_LINE: begin
          if (byte_r == CHAR_LF) begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_COMMENT, token_begin, len, '0);
            mode_next = MODE_IDLE;
          end
        end
        MODE_BLOCK: begin
          if (star_seen && byte_r == CHAR_SLASH) begin
            em_a      = 1'b1;
            tok_a     = make_token(KIND_COMMENT, token_begin, len + POSITION_BITS'(1), '0);
            mode_next = MODE_IDLE;
            star_next = 1'b0;
          end else begin
            star_next = (byte_r == CHAR_STAR);
          end
        end
        MODE_STRAY: begin
          if (byte_r == CHAR_LF) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
          disp      = 1'b1;
        end
      endcase

      // close the identifier on a byte that is neither a letter nor an underscore and lex the byte anew
      if (ident_chk && !is_ident_char(byte_r)) begin
        em_b      = 1'b1;
        tok_b     = make_token(KIND_IDENT, begin_next, byte_position - begin_next, '0);
        mode_next = MODE_IDLE;
        disp      = 1'b1;
      end

      if (disp) begin
        priority if (byte_r == CHAR_HASH) begin
          mode_next    = MODE_KEYWORD;
          begin_next   = byte_position;
          matched_next = 3'd1;
        end else if (byte_r == CHAR_QUOTE) begin
          mode_next  = MODE_STRING;
          begin_next = byte_position + POSITION_BITS'(1);
        end else if (is_digit_char(byte_r)) begin
          mode_next  = MODE_NUMBER;
          begin_next = byte_position;
          acc_next   = ACC_BITS'(byte_r[3:0]);
        end else if (is_ident_char(byte_r)) begin
          mode_next  = MODE_IDENT;
          begin_next = byte_position;
        end else if (byte_r == CHAR_OPEN) begin
          em_c  = 1'b1;
          tok_c = make_token(KIND_OPEN, byte_position, POSITION_BITS'(1), '0);
        end else if (byte_r == CHAR_CLOSE) begin
          em_c  = 1'b1;
          tok_c = make_token(KIND_CLOSE, byte_position, POSITION_BITS'(1), '0);
        end else if (byte_r == CHAR_COMMA) begin
          em_c  = 1'b1;
          tok_c = make_token(KIND_COMMA, byte_position, POSITION_BITS'(1), '0);
        end else if (byte_r == CHAR_SLASH) begin
          mode_next  = MODE_SLASH;
          begin_next = byte_position;
        end else begin
          mode_next = MODE_IDLE;
        end
      end
    end
  end

  // pack the emitted tokens in order, mark the final one
  always_comb begin
    n    = 2'd0;
    tok0 = '0;
    tok1 = '0;
    if (em_a) begin
      tok0 = tok_a;
      n    = 2'd1;
    end
    if (em_b) begin
      if (n == 2'd0) begin
        tok0 = tok_b;
      end else begin
        tok1 = tok_b;
      end
      n = n + 2'd1;
    end
    if (em_c) begin
      if (n == 2'd0) begin
        tok0 = tok_c;
      end else begin
        tok1 = tok_c;
      end
      n = n + 2'd1;
    end
    if (n == 2'd1) begin
      tok0.last = 1'b1;
    end
    if (n == 2'd2) begin
      tok1.last = 1'b1;
    end
  end

  assign push.count = step ? n : 2'd0;
  assign push.tok0  = tok0;
  assign push.tok1  = tok1;

endmodule

FILE: sv/dtt_token_queue.sv
// ----------------------------------------------------------------------------
// Directive text tokenizer token queue
// Small queue that takes up to two tokens a cycle while it has room for two, and hands out one unless stalled.
// ----------------------------------------------------------------------------
module dtt_token_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  dtt_pkg::push_t                    push,
  output logic                              room,
  output logic                              token_valid,
  input  logic                              token_stall,
  output dtt_pkg::token_t                   head_token
);
  import dtt_pkg::*;

  token_t             entries [QUEUE_DEPTH];
  logic [QIDX_W-1:0]  head;
  logic [QIDX_W-1:0]  tail;
  logic [QCNT_W-1:0]  count;
  logic               pop;

  assign token_valid = (count != '0);
  assign pop         = token_valid && !token_stall;
  assign room        = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head_token  = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + QIDX_W'(1);
      end
      tail  <= tail + QIDX_W'(push.count);
      count <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[tail] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entries[tail + QIDX_W'(1)] <= push.tok1;
    end
  end

endmodule

FILE: sv/directive_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Directive text tokenizer core
// Streaming lexer for directive text: one byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register; once the token queue
//   has room, the lexer step writes its tokens into the queue, which offers them.
// Throughput: one byte per cycle while the token queue has room for two; the
//   two tokens of one byte leave one at a time, absorbed by the 4-entry token queue.
// Reset: synchronous rst clears the lexer state, byte offset and the queue.
module directive_text_tokenizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  logic [7:0]         text_byte,
  output logic               token_valid,
  input  logic               token_stall,
  output logic [2:0]         token_kind,
  output logic [15:0]        token_start,
  output logic [15:0]        token_length,
  output logic signed [36:0] number_value,
  output logic               last_of_run
);
  import dtt_pkg::*;

  push_t  push;
  logic   room;
  token_t head_token;

  dtt_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .room       (room),
    .push       (push)
  );

  dtt_token_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .head_token  (head_token)
  );

  assign token_kind   = 3'(head_token.kind);
  assign token_start  = 16'(head_token.start);
  assign token_length = 16'(head_token.length);
  assign number_value = $signed(head_token.value);
  assign last_of_run  = head_token.last;

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("token push without queue room");

  a_pair_last_mark: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (!push.tok0.last && push.tok1.last))
    else $error("two-token request marks wrong final token");

  a_include_length: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0 && push.tok0.kind == KIND_INCLUDE) |->
      push.tok0.length == INCLUDE_LENGTH)
    else $error("include token with wrong length");

  a_value_only_number: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_kind != 3'(KIND_NUMBER)) |-> number_value == '0)
    else $error("nonzero value on a non-number token");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Directive text tokenizer testbench
// Streams source bytes into the tokenizer under random valid and stall
// pressure. Each accepted byte runs through a lexer predictor that queues
// the tokens it should produce. Every token the block hands out is checked
// field by field against the oldest queued token.
// ----------------------------------------------------------------------------
module tb_top;
  import dtt_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_BYTES = 1300;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [15:0] INCLUDE_SPAN = 16'd8;
  localparam logic [63:0] KEYWORD_TEXT = "#include";

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               text_valid = 1'b0;
  logic               text_stall;
  logic [7:0]         text_byte = 8'h00;
  logic               token_valid;
  logic               token_stall = 1'b0;
  logic [2:0]         token_kind;
  logic [15:0]        token_start;
  logic [15:0]        token_length;
  logic signed [36:0] number_value;
  logic               last_of_run;

  // lexer predictor state
  mode_t       lex_mode;
  logic [15:0] byte_pos;
  logic [15:0] tok_begin;
  int          kw_count;
  logic [31:0] digits;
  logic        star;
  token_t      step_tok [2];
  int          n_out;

  token_t      expected_tokens [$];
  logic [7:0]  text_q [$];
  token_t      want;

  bit src_quiet  = 1'b0;
  bit sink_quiet = 1'b0;
  int hold_left;
  int failures = 0;
  int bytes_sent = 0;
  int texts_ended = 0;
  int tokens_seen = 0;
  int paired_bytes = 0;

  directive_text_tokenizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .number_value (number_value),
    .last_of_run  (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_name_char(input logic [7:0] c);
    return c == CHAR_UNDER || (c >= CHAR_LO_A && c <= CHAR_LO_Z) ||
           (c >= CHAR_UP_A && c <= CHAR_UP_Z);
  endfunction

  function automatic bit is_num_char(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic logic [7:0] keyword_byte(input int idx);
    return KEYWORD_TEXT[8*(7-idx) +: 8];
  endfunction

  function automatic logic [36:0] pack_number(input logic [31:0] acc, input bit with_tag,
                                              input logic [7:0] tag);
    logic [36:0] v;
    v = 37'(acc);
    if (with_tag) v = (v << TAG_BITS) | 37'(tag & TAG_MASK);
    return 37'(0) - v;
  endfunction

  function automatic void add_token(input kind_t k, input logic [15:0] s,
                                    input logic [15:0] l, input logic [36:0] v);
    if (n_out < 2) begin
      step_tok[n_out].kind   = k;
      step_tok[n_out].start  = s;
      step_tok[n_out].length = l;
      step_tok[n_out].value  = v;
      step_tok[n_out].last   = 1'b0;
      n_out++;
    end
  endfunction

  function automatic void reset_lexer();
    lex_mode  = MODE_IDLE;
    byte_pos  = '0;
    tok_begin = '0;
    kw_count  = 0;
    digits    = '0;
    star      = 1'b0;
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    logic [15:0] span;
    logic [35:0] grown;
    bit again;
    span = byte_pos - tok_begin;
    n_out = 0;
    if (c == CHAR_NUL) begin
      // end of text: flush whatever is pending, then start over at offset 0
      case (lex_mode)
        MODE_KEYWORD: if (kw_count >= 2)
                        add_token(KIND_IDENT, tok_begin + 16'd1, 16'(kw_count - 1), '0);
        MODE_NUMBER:  add_token(KIND_NUMBER, tok_begin, span, pack_number(digits, 0, '0));
        MODE_IDENT:   add_token(KIND_IDENT, tok_begin, span, '0);
        MODE_LINE, MODE_BLOCK: add_token(KIND_COMMENT, tok_begin, span, '0);
        default: ;
      endcase
      reset_lexer();
      texts_ended++;
    end else begin
      again = 1'b1;
      for (int pass = 0; pass < 3 && again; pass++) begin
        again = 1'b0;
        span = byte_pos - tok_begin;
        case (lex_mode)
          MODE_KEYWORD: begin
            if (kw_count < 8 && c == keyword_byte(kw_count)) begin
              kw_count++;
              if (kw_count == 8) begin
                add_token(KIND_INCLUDE, tok_begin, INCLUDE_SPAN, '0);
                lex_mode = MODE_IDLE;
                kw_count = 0;
              end
            end else begin
              // drop the hash; matched letters become an identifier
              if (kw_count >= 2) begin
                lex_mode  = MODE_IDENT;
                tok_begin = tok_begin + 16'd1;
              end else begin
                lex_mode = MODE_IDLE;
              end
              kw_count = 0;
              again = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c == CHAR_QUOTE) begin
              add_token(KIND_STRING, tok_begin, span, '0);
              lex_mode = MODE_IDLE;
            end else if (c == CHAR_LF) begin
              lex_mode = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (is_num_char(c)) begin
              grown = 36'(digits) * 36'd10 + 36'(c - CHAR_ZERO);
              digits = (grown > 36'hFFFF_FFFF) ? '1 : grown[31:0];
            end else if (c == CHAR_UP_V) begin
              add_token(KIND_NUMBER, tok_begin, span + 16'd1, pack_number(digits, 1, VARIABLE_TAG));
              lex_mode = MODE_IDLE;
            end else if (c == CHAR_UP_P || c == CHAR_UP_C) begin
              add_token(KIND_NUMBER, tok_begin, span + 16'd1,
                        pack_number(digits, 1, PARAMETER_TAG));
              lex_mode = MODE_IDLE;
            end else begin
              add_token(KIND_NUMBER, tok_begin, span, pack_number(digits, 0, '0));
              lex_mode = MODE_IDLE;
              again = 1'b1;
            end
            if (lex_mode == MODE_IDLE) digits = '0;
          end
          MODE_IDENT: begin
            if (!is_name_char(c)) begin
              add_token(KIND_IDENT, tok_begin, span, '0);
              lex_mode = MODE_IDLE;
              again = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (c == CHAR_SLASH) begin
              lex_mode = MODE_LINE;
            end else if (c == CHAR_STAR) begin
              lex_mode = MODE_BLOCK;
              star = 1'b0;
            end else if (c == CHAR_LF) begin
              lex_mode = MODE_IDLE;
            end else begin
              lex_mode = MODE_STRAY;
            end
          end
          MODE_LINE: begin
            if (c == CHAR_LF) begin
              add_token(KIND_COMMENT, tok_begin, span, '0);
              lex_mode = MODE_IDLE;
            end
          end
          MODE_BLOCK: begin
            if (star && c == CHAR_SLASH) begin
              add_token(KIND_COMMENT, tok_begin, span + 16'd1, '0);
              lex_mode = MODE_IDLE;
              star = 1'b0;
            end else begin
              star = (c == CHAR_STAR);
            end
          end
          MODE_STRAY: begin
            if (c == CHAR_LF) lex_mode = MODE_IDLE;
          end
          default: begin
            lex_mode = MODE_IDLE;
            if (c == CHAR_HASH) begin
              lex_mode = MODE_KEYWORD;
              tok_begin = byte_pos;
              kw_count = 1;
            end else if (c == CHAR_QUOTE) begin
              lex_mode = MODE_STRING;
              tok_begin = byte_pos + 16'd1;
            end else if (is_num_char(c)) begin
              lex_mode = MODE_NUMBER;
              tok_begin = byte_pos;
              digits = 32'(c - CHAR_ZERO);
            end else if (is_name_char(c)) begin
              lex_mode = MODE_IDENT;
              tok_begin = byte_pos;
            end else if (c == CHAR_OPEN) begin
              add_token(KIND_OPEN, byte_pos, 16'd1, '0);
            end else if (c == CHAR_CLOSE) begin
              add_token(KIND_CLOSE, byte_pos, 16'd1, '0);
            end else if (c == CHAR_COMMA) begin
              add_token(KIND_COMMA, byte_pos, 16'd1, '0);
            end else if (c == CHAR_SLASH) begin
              lex_mode = MODE_SLASH;
              tok_begin = byte_pos;
            end
          end
        endcase
      end
      byte_pos = byte_pos + 16'd1;
    end
    if (n_out > 0) step_tok[n_out-1].last = 1'b1;
    if (n_out == 2) paired_bytes++;
    for (int i = 0; i < n_out; i++)
      expected_tokens.insert(expected_tokens.size(), step_tok[i]);
  endfunction

  // ------------------------------------------------------------ token checker

  task automatic note_failure(input string what);
    failures++;
    if (failures <= 10)
      $display("mismatch at %0t: %s; got kind %0d start %0d len %0d value %0d last %0d",
               $time, what, token_kind, token_start, token_length, number_value,
               last_of_run);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_left = 0;
      token_stall <= 1'b0;
    end else begin
      if (token_valid && !token_stall) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          note_failure("no token expected");
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind || token_start !== want.start ||
              token_length !== want.length || number_value !== want.value ||
              last_of_run !== want.last)
            note_failure($sformatf("expected kind %0d start %0d len %0d value %0d last %0d",
                                   want.kind, want.start, want.length,
                                   $signed(want.value), want.last));
        end
        hold_left = sink_quiet ? 0 : $urandom_range(0, 11);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      token_stall <= (hold_left > 0);
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= c;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    lex_byte(c);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
  endtask

  // lower valid and wait until every predicted token has come out
  task automatic drain();
    text_valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
  endtask

  function automatic void queue_byte(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    int n;
    n = $urandom_range(0, 52);
    if (n < 26) return CHAR_LO_A + 8'(n);
    if (n < 52) return CHAR_UP_A + 8'(n - 26);
    return CHAR_UNDER;
  endfunction

  function automatic logic [7:0] rand_filler(input logic [7:0] stop);
    logic [7:0] b;
    b = stop;
    while (b == stop || b == CHAR_LF || b == CHAR_NUL) begin
      case ($urandom_range(0, 3))
        0:       b = rand_letter();
        1:       b = CHAR_STAR;
        2:       b = CHAR_SPACE;
        default: b = 8'($urandom_range(1, 255));
      endcase
    end
    return b;
  endfunction

  // append one lexical fragment, mostly well formed, to the byte queue
  function automatic void add_fragment();
    int n;
    case ($urandom_range(0, 19))
      0, 1: push_str("#include");
      2: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) queue_byte(keyword_byte(i));
      end
      3, 4: begin
        queue_byte(CHAR_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) queue_byte(rand_filler(CHAR_QUOTE));
        queue_byte(($urandom_range(0, 4) == 0) ? CHAR_LF : CHAR_QUOTE);
      end
      5, 6, 7: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        repeat (n) queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        case ($urandom_range(0, 5))
          0: queue_byte(CHAR_UP_V);
          1: queue_byte(CHAR_UP_P);
          2: queue_byte(CHAR_UP_C);
          default: ;
        endcase
      end
      8, 9, 10: begin
        n = $urandom_range(1, 6);
        repeat (n) queue_byte(rand_letter());
      end
      11: begin
        case ($urandom_range(0, 2))
          0:       queue_byte(CHAR_OPEN);
          1:       queue_byte(CHAR_CLOSE);
          default: queue_byte(CHAR_COMMA);
        endcase
      end
      12: begin
        push_str("//");
        n = $urandom_range(0, 6);
        repeat (n) queue_byte(rand_filler(CHAR_LF));
        queue_byte(CHAR_LF);
      end
      13: begin
        push_str("/*");
        n = $urandom_range(0, 8);
        repeat (n) queue_byte(($urandom_range(0, 5) == 0) ? CHAR_SLASH :
                              rand_filler(CHAR_SLASH));
        if ($urandom_range(0, 5) != 0) push_str("*/");
      end
      14: begin
        queue_byte(CHAR_SLASH);
        queue_byte(rand_letter());
        n = $urandom_range(0, 4);
        repeat (n) queue_byte(rand_filler(CHAR_LF));
        queue_byte(CHAR_LF);
      end
      15, 16: begin
        case ($urandom_range(0, 2))
          0:       queue_byte(CHAR_SPACE);
          1:       queue_byte(CHAR_LF);
          default: queue_byte(CHAR_TAB);
        endcase
      end
      17:      queue_byte(8'($urandom_range(1, 255)));
      18:      queue_byte(CHAR_NUL);
      default: queue_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  // ---------------------------------------------------------------- test list

  task automatic test_keyword_and_operators();
    push_str("#includeZ#in(#x,#i)");
    queue_byte(CHAR_NUL);
    send_queued();
    drain();
  endtask

  task automatic test_number_tags();
    push_str("7V 99999999999P 0C 12)");
    queue_byte(CHAR_NUL);
    send_queued();
    drain();
  endtask

  task automatic test_strings_and_comments();
    push_str("\"a\"\"b\n/x\n//c\n/*a**/ \"\"");
    queue_byte(8'hFF);
    push_str("/*");
    queue_byte(CHAR_NUL);
    send_queued();
    drain();
  endtask

  task automatic test_end_of_text_flush();
    push_str("ab");
    queue_byte(CHAR_NUL);
    push_str("3");
    queue_byte(CHAR_NUL);
    push_str("#in");
    queue_byte(CHAR_NUL);
    push_str("//");
    queue_byte(CHAR_NUL);
    send_queued();
    drain();
  endtask

  task automatic test_random_text();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (text_q.size() == 0) add_fragment();
      // switch between idle-heavy and back-to-back stretches
      if ($urandom_range(0, 63) == 0) begin
        src_quiet  = ($urandom_range(0, 3) == 0);
        sink_quiet = ($urandom_range(0, 3) == 0);
      end
      send_byte(text_q.pop_front());
      sent++;
    end
    text_q.delete();
    queue_byte(CHAR_NUL);
    send_queued();
    drain();
  endtask

  initial begin
    reset_lexer();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_keyword_and_operators();
    test_number_tags();
    test_strings_and_comments();
    test_end_of_text_flush();
    test_random_text();
    repeat (20) @(posedge clk);
    $display("sent %0d source bytes over %0d texts", bytes_sent, texts_ended);
    $display("checked %0d tokens, %0d bytes gave two tokens, %0d failures", tokens_seen,
             paired_bytes, failures);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/dtt_pkg.sv
sv/dtt_lexer.sv
sv/dtt_token_queue.sv
sv/directive_text_tokenizer_core.sv
dv/tb_top.sv
